>>> src/jcds_pkg.sv
// Shared types and constants for the joystick center and deadzone block.
package jcds_pkg;

  // Deadzone register
  localparam int DEADZONE_W = 12;
  typedef logic [DEADZONE_W-1:0] deadzone_t;
  localparam deadzone_t DEADZONE_RESET = deadzone_t'(260);

  // Axis step codes, two's complement
  typedef logic signed [1:0] step_t;
  localparam step_t STEP_ZERO = 2'sb00;
  localparam step_t STEP_POS  = 2'sb01;
  localparam step_t STEP_NEG  = 2'sb11;

endpackage

>>> src/jcds_if.sv
// Valid/ready channels for sample items and step result items.
interface jcds_sample_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] sample_x;
  logic [ADC_BITS-1:0] sample_y;
  logic                switch_low;

  modport source (output valid, output sample_x, output sample_y, output switch_low,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input switch_low,
                  output ready);
endinterface

interface jcds_step_if;
  import jcds_pkg::*;

  logic  valid;
  logic  ready;
  step_t step_x;
  step_t step_y;
  logic  press_event;

  modport source (output valid, output step_x, output step_y, output press_event,
                  input ready);
  modport sink   (input valid, input step_x, input step_y, input press_event,
                  output ready);
endinterface

>>> src/jcds_axis.sv
// One axis: compare a group sum against center and deadzone, give -1, 0 or +1.
module jcds_axis #(
  parameter int ADC_BITS   = 12,
  parameter int SUM_W      = 16,
  parameter int READ_COUNT = 4
) (
  input  logic [SUM_W-1:0]    sum,
  input  logic [ADC_BITS-1:0] center,
  input  jcds_pkg::deadzone_t deadzone,
  output jcds_pkg::step_t     step
);
  import jcds_pkg::*;

  localparam int BASE_W = ((ADC_BITS > DEADZONE_W) ? ADC_BITS : DEADZONE_W) + 1;
  localparam int PROD_W = BASE_W + $clog2(READ_COUNT + 1);
  localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  logic [BASE_W-1:0] upper;
  logic [BASE_W-1:0] gap;
  logic [PROD_W-1:0] hi;
  logic [PROD_W-1:0] lo;
  logic              center_gt_dz;
  logic              above;
  logic              below;

  // The truncated mean sum/READ_COUNT exceeds center+deadzone exactly when
  // sum >= READ_COUNT*(center+deadzone+1); it falls below center-deadzone
  // exactly when sum < READ_COUNT*(center-deadzone), which needs center > deadzone.
  always_comb begin
    upper        = BASE_W'(center) + BASE_W'(deadzone) + BASE_W'(1);
    gap          = BASE_W'(center) - BASE_W'(deadzone);
    center_gt_dz = BASE_W'(center) > BASE_W'(deadzone);
    hi           = PROD_W'(upper) * PROD_W'(READ_COUNT);
    lo           = PROD_W'(gap) * PROD_W'(READ_COUNT);
    above        = CMP_W'(sum) >= CMP_W'(hi);
    below        = center_gt_dz && (CMP_W'(sum) < CMP_W'(lo));
    if (above) begin
      step = STEP_POS;
    end else if (below) begin
      step = STEP_NEG;
    end else begin
      step = STEP_ZERO;
    end
  end

endmodule

>>> src/joystick_center_deadzone_step.sv
// Joystick center calibration, group averaging, deadzone stepping and press detect.
//
// One sample item is accepted every clock cycle. The first CENTER_COUNT items
// after reset set the center and give no result; after that every READ_COUNT
// items give one result. The edge that accepts a group's last item loads the
// capture stage, and the compare is loaded into the output register when the
// capture stage hands on its group; the result is offered from there. The
// input side only stalls when a finished group waits in the capture stage while
// the output register holds a result not yet taken. The center division is a
// multiply by a constant reciprocal in the capture stage.
module joystick_center_deadzone_step #(
  parameter int CENTER_COUNT = 16,
  parameter int READ_COUNT   = 4,
  parameter int ADC_BITS     = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  jcds_pkg::deadzone_t cfg_data,
  jcds_sample_if.sink         samples,
  jcds_step_if.source         steps
);
  import jcds_pkg::*;

  localparam int MAX_COUNT = (CENTER_COUNT > READ_COUNT) ? CENTER_COUNT : READ_COUNT;
  localparam int SUM_W     = ADC_BITS + $clog2(MAX_COUNT);
  localparam int CNT_W     = ($clog2(MAX_COUNT) > 0) ? $clog2(MAX_COUNT) : 1;
  localparam int RECIP_K   = SUM_W + $clog2(CENTER_COUNT);
  localparam int MUL_W     = SUM_W + RECIP_K + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << RECIP_K) + 64'(CENTER_COUNT) - 64'd1) / 64'(CENTER_COUNT);
  localparam logic [RECIP_K:0] RECIP = RECIP_FULL[RECIP_K:0];
  localparam logic [CNT_W-1:0] CAL_LAST   = CNT_W'(CENTER_COUNT - 1);
  localparam logic [CNT_W-1:0] GROUP_LAST = CNT_W'(READ_COUNT - 1);

  // Accumulation state
  logic                calibrating;
  logic [CNT_W-1:0]    sample_count;
  logic [SUM_W-1:0]    sum_x;
  logic [SUM_W-1:0]    sum_y;
  logic [ADC_BITS-1:0] mid_x;
  logic [ADC_BITS-1:0] mid_y;
  logic                switch_was_low;
  deadzone_t           deadzone;

  // Capture stage: one finished phase (calibration or group)
  logic                s1_valid;
  logic                s1_cal;
  logic [SUM_W-1:0]    s1_sum_x;
  logic [SUM_W-1:0]    s1_sum_y;
  logic                s1_sw;

  // Output register
  logic                out_valid;
  step_t               out_step_x;
  step_t               out_step_y;
  logic                out_press;

  logic                accept;
  logic                last_item;
  logic                s1_hold;
  logic                s1_take;
  logic [SUM_W-1:0]    sum_x_next;
  logic [SUM_W-1:0]    sum_y_next;
  logic [MUL_W-1:0]    mul_x;
  logic [MUL_W-1:0]    mul_y;
  step_t               step_x_calc;
  step_t               step_y_calc;

  // Handshake and phase control
  always_comb begin
    s1_hold    = s1_valid && !s1_cal && out_valid && !steps.ready;
    s1_take    = s1_valid && !s1_hold;
    accept     = samples.valid && samples.ready;
    last_item  = calibrating ? (sample_count == CAL_LAST) : (sample_count == GROUP_LAST);
    sum_x_next = sum_x + SUM_W'(samples.sample_x);
    sum_y_next = sum_y + SUM_W'(samples.sample_y);
    mul_x      = MUL_W'(s1_sum_x) * MUL_W'(RECIP);
    mul_y      = MUL_W'(s1_sum_y) * MUL_W'(RECIP);
  end

  assign samples.ready     = !s1_hold;
  assign steps.valid       = out_valid;
  assign steps.step_x      = out_step_x;
  assign steps.step_y      = out_step_y;
  assign steps.press_event = out_press;

  jcds_axis #(
    .ADC_BITS   (ADC_BITS),
    .SUM_W      (SUM_W),
    .READ_COUNT (READ_COUNT)
  ) u_axis_x (
    .sum      (s1_sum_x),
    .center   (mid_x),
    .deadzone (deadzone),
    .step     (step_x_calc)
  );

  jcds_axis #(
    .ADC_BITS   (ADC_BITS),
    .SUM_W      (SUM_W),
    .READ_COUNT (READ_COUNT)
  ) u_axis_y (
    .sum      (s1_sum_y),
    .center   (mid_y),
    .deadzone (deadzone),
    .step     (step_y_calc)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= DEADZONE_RESET;
    end else if (cfg_we) begin
      deadzone <= cfg_data;
    end
  end

  // Accumulate items; on the last item of a phase hand the sums to capture
  always_ff @(posedge clk) begin
    if (rst) begin
      calibrating  <= 1'b1;
      sample_count <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
    end else if (accept) begin
      if (last_item) begin
        calibrating  <= 1'b0;
        sample_count <= '0;
        sum_x        <= '0;
        sum_y        <= '0;
      end else begin
        sample_count <= sample_count + CNT_W'(1);
        sum_x        <= sum_x_next;
        sum_y        <= sum_y_next;
      end
    end
  end

  // Capture stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && last_item) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture stage payload
  always_ff @(posedge clk) begin
    if (accept && last_item) begin
      s1_cal   <= calibrating;
      s1_sum_x <= sum_x_next;
      s1_sum_y <= sum_y_next;
      s1_sw    <= samples.switch_low;
    end
  end

  // Store the center: truncated mean by reciprocal multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_x <= '0;
      mid_y <= '0;
    end else if (s1_take && s1_cal) begin
      mid_x <= mul_x[RECIP_K +: ADC_BITS];
      mid_y <= mul_y[RECIP_K +: ADC_BITS];
    end
  end

  // Switch edge memory and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_was_low <= 1'b0;
      out_valid      <= 1'b0;
    end else if (s1_take && !s1_cal) begin
      switch_was_low <= s1_sw;
      out_valid      <= 1'b1;
    end else if (steps.ready) begin
      out_valid      <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s1_take && !s1_cal) begin
      out_step_x <= step_x_calc;
      out_step_y <= step_y_calc;
      out_press  <= s1_sw && !switch_was_low;
    end
  end

  // Calibration ends only by handing a calibration sum to the capture stage
  a_cal_end: assert property (@(posedge clk) disable iff (rst)
    $fell(calibrating) |-> (s1_valid && s1_cal))
    else $error("calibration ended without a captured center sum");

  // No result appears before calibration has finished
  a_no_result_cal: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !calibrating)
    else $error("result produced during calibration");

  // Count stays inside the current phase length
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    calibrating ? (sample_count <= CAL_LAST) : (sample_count <= GROUP_LAST))
    else $error("sample count beyond phase length");

  // A result never carries the unused step code
  a_step_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_step_x != 2'sb10) && (out_step_y != 2'sb10))
    else $error("invalid step code in result");

  // A calibration capture never stalls behind the output register
  a_cal_flow: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_cal) |=> !(s1_valid && s1_cal) || $past(accept && last_item))
    else $error("calibration capture held for more than one cycle");

endmodule
